// ===== hdl/perq_pkg.sv =====
// Shared types, constants and ring-index helper for the priority evicting ring queue.
package perq_pkg;

    localparam int CAPACITY      = 16;
    localparam int PAYLOAD_WIDTH = 32;

    localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int PRIO_W = 3;
    localparam int PORT_W = 32;
    localparam int FILL_W = 5;
    localparam int DROP_W = 32;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    typedef logic [IDX_W-1:0]         idx_t;
    typedef logic [CNT_W-1:0]         cnt_t;
    typedef logic [CNT_W:0]           sum_t;
    typedef logic [PRIO_W-1:0]        prio_t;
    typedef logic [PAYLOAD_WIDTH-1:0] data_t;

    typedef struct packed {
        prio_t prio;
        data_t data;
    } slot_t;

    typedef struct packed {
        logic load;
        logic first;
    } scan_ctl_t;

    // slot of the entry at a given age; base < CAPACITY, age <= CAPACITY
    function automatic idx_t ring_idx(idx_t base, cnt_t age);
        sum_t sum;
        sum = sum_t'(base) + sum_t'(age);
        if (sum >= sum_t'(CAPACITY))
        begin
            sum = sum - sum_t'(CAPACITY);
        end
        return idx_t'(sum);
    endfunction

endpackage

// ===== hdl/perq_scan.sv =====
// Shared compare unit: running minimum priority and age of its oldest holder.
module perq_scan (
    input  logic                clk,
    input  perq_pkg::scan_ctl_t ctl,
    input  perq_pkg::prio_t     prio,
    input  perq_pkg::cnt_t      age,
    output perq_pkg::prio_t     low_prio,
    output perq_pkg::cnt_t      victim_age
);
    import perq_pkg::*;

    prio_t low_reg;
    cnt_t  victim_reg;

    // strict less-than keeps the oldest entry on a tie
    always_ff @(posedge clk)
    begin
        if (ctl.load && (ctl.first || (prio < low_reg)))
        begin
            low_reg    <= prio;
            victim_reg <= age;
        end
    end

    assign low_prio   = low_reg;
    assign victim_age = victim_reg;

endmodule

// ===== hdl/perq_seq.sv =====
// Sequencer, slot memory and result registers of the priority evicting ring queue.
module perq_seq (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       op,
    input  perq_pkg::prio_t            in_priority,
    input  logic [perq_pkg::PORT_W-1:0] in_payload,
    output perq_pkg::scan_ctl_t        scan_ctl,
    output perq_pkg::prio_t            scan_prio,
    output perq_pkg::cnt_t             scan_age,
    input  perq_pkg::prio_t            low_prio,
    input  perq_pkg::cnt_t             victim_age,
    output logic                       done,
    output logic                       push_stored,
    output logic                       evicted_one,
    output logic                       pop_valid,
    output perq_pkg::prio_t            out_priority,
    output logic [perq_pkg::PORT_W-1:0] out_payload,
    output logic [perq_pkg::FILL_W-1:0] fill_level,
    output logic [perq_pkg::DROP_W-1:0] drop_total
);
    import perq_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_POP,
        S_SCAN,
        S_DECIDE,
        S_SHIFT,
        S_APPEND
    } state_t;

    typedef struct packed {
        logic              stored;
        logic              evicted;
        logic              valid;
        prio_t             prio;
        logic [PORT_W-1:0] data;
    } res_t;

    state_t             state_reg, state_next;
    cnt_t               age_reg, age_next;
    idx_t               head_reg, head_next;
    cnt_t               count_reg, count_next;
    logic [DROP_W-1:0]  drop_reg, drop_next;
    prio_t              prio_reg, prio_next;
    data_t              data_reg, data_next;
    res_t               res_reg, res_next;
    logic               done_reg, done_next;

    slot_t              mem [CAPACITY];
    slot_t              rd_data_reg;
    idx_t               rd_addr;
    logic               wr_en;
    idx_t               wr_addr;
    slot_t              wr_data;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_comb
    begin
        state_next = state_reg;
        age_next   = age_reg;
        head_next  = head_reg;
        count_next = count_reg;
        drop_next  = drop_reg;
        prio_next  = prio_reg;
        data_next  = data_reg;
        res_next   = res_reg;
        done_next  = 1'b0;
        rd_addr    = head_reg;
        wr_en      = 1'b0;
        wr_addr    = head_reg;
        wr_data    = '{prio: prio_reg, data: data_reg};
        scan_ctl   = '{load: 1'b0, first: 1'b0};
        scan_age   = age_reg - cnt_t'(1);

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    prio_next = in_priority;
                    data_next = data_t'(in_payload);
                    if (op == OP_POP)
                    begin
                        if (count_reg == '0)
                        begin
                            res_next  = '0;
                            done_next = 1'b1;
                        end
                        else
                        begin
                            rd_addr    = head_reg;
                            state_next = S_POP;
                        end
                    end
                    else if (count_reg != cnt_t'(CAPACITY))
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = ring_idx(head_reg, count_reg);
                        wr_data    = '{prio: in_priority, data: data_t'(in_payload)};
                        count_next = count_reg + cnt_t'(1);
                        res_next   = '{stored: 1'b1, evicted: 1'b0, valid: 1'b0,
                                       prio: '0, data: '0};
                        done_next  = 1'b1;
                    end
                    else
                    begin
                        rd_addr    = head_reg;
                        age_next   = cnt_t'(1);
                        state_next = S_SCAN;
                    end
                end
            end
            S_POP:
            begin
                res_next   = '{stored: 1'b0, evicted: 1'b0, valid: 1'b1,
                               prio: rd_data_reg.prio,
                               data: PORT_W'(rd_data_reg.data)};
                head_next  = ring_idx(head_reg, cnt_t'(1));
                count_next = count_reg - cnt_t'(1);
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            S_SCAN:
            begin
                // read data belongs to age age_reg - 1
                scan_ctl = '{load: 1'b1, first: (age_reg == cnt_t'(1))};
                if (age_reg != count_reg)
                begin
                    rd_addr  = ring_idx(head_reg, age_reg);
                    age_next = age_reg + cnt_t'(1);
                end
                else
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (drop_reg != '1)
                begin
                    drop_next = drop_reg + DROP_W'(1);
                end
                if (prio_reg < low_prio)
                begin
                    res_next   = '0;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else if (victim_age == count_reg - cnt_t'(1))
                begin
                    state_next = S_APPEND;
                end
                else
                begin
                    rd_addr    = ring_idx(head_reg, victim_age + cnt_t'(1));
                    age_next   = victim_age + cnt_t'(1);
                    state_next = S_SHIFT;
                end
            end
            S_SHIFT:
            begin
                // close the gap: entry at age_reg moves one place older
                wr_en   = 1'b1;
                wr_addr = ring_idx(head_reg, age_reg - cnt_t'(1));
                wr_data = rd_data_reg;
                if (age_reg + cnt_t'(1) != count_reg)
                begin
                    rd_addr  = ring_idx(head_reg, age_reg + cnt_t'(1));
                    age_next = age_reg + cnt_t'(1);
                end
                else
                begin
                    state_next = S_APPEND;
                end
            end
            S_APPEND:
            begin
                wr_en      = 1'b1;
                wr_addr    = ring_idx(head_reg, count_reg - cnt_t'(1));
                res_next   = '{stored: 1'b1, evicted: 1'b1, valid: 1'b0,
                               prio: '0, data: '0};
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            age_reg   <= '0;
            head_reg  <= '0;
            count_reg <= '0;
            drop_reg  <= '0;
            prio_reg  <= '0;
            data_reg  <= '0;
            res_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            age_reg   <= age_next;
            head_reg  <= head_next;
            count_reg <= count_next;
            drop_reg  <= drop_next;
            prio_reg  <= prio_next;
            data_reg  <= data_next;
            res_reg   <= res_next;
            done_reg  <= done_next;
        end
    end

    assign scan_prio    = rd_data_reg.prio;
    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign push_stored  = res_reg.stored;
    assign evicted_one  = res_reg.evicted;
    assign pop_valid    = res_reg.valid;
    assign out_priority = res_reg.prio;
    assign out_payload  = res_reg.data;
    assign fill_level   = FILL_W'(count_reg);
    assign drop_total   = drop_reg;

endmodule

// ===== hdl/priority_evicting_ring_queue.sv =====
// Top level of the priority evicting ring queue.
// A command is taken on a clock edge with start high and busy low; its one result beat
// appears with done high for exactly one cycle and must be captured then. A push into a
// queue that is not full, and a pop of an empty queue, return done on the next cycle; a pop
// of a stored sample passes through S_POP for the registered memory read. A push into a full
// queue reads every slot through the single memory port into the shared compare unit, then
// drops the new sample if its priority is below the lowest stored one; else it evicts the
// oldest lowest-priority entry, moves the entries younger than it one per cycle and appends.
// A new command may be started in the cycle that done is high. Fill level and drop total on
// the result beat are the values after that command.
module priority_evicting_ring_queue (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        op,
    input  perq_pkg::prio_t             in_priority,
    input  logic [perq_pkg::PORT_W-1:0] in_payload,
    output logic                        done,
    output logic                        push_stored,
    output logic                        evicted_one,
    output logic                        pop_valid,
    output perq_pkg::prio_t             out_priority,
    output logic [perq_pkg::PORT_W-1:0] out_payload,
    output logic [perq_pkg::FILL_W-1:0] fill_level,
    output logic [perq_pkg::DROP_W-1:0] drop_total
);
    import perq_pkg::*;

    scan_ctl_t scan_ctl;
    prio_t     scan_prio;
    cnt_t      scan_age;
    prio_t     low_prio;
    cnt_t      victim_age;

    perq_seq u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .op           (op),
        .in_priority  (in_priority),
        .in_payload   (in_payload),
        .scan_ctl     (scan_ctl),
        .scan_prio    (scan_prio),
        .scan_age     (scan_age),
        .low_prio     (low_prio),
        .victim_age   (victim_age),
        .done         (done),
        .push_stored  (push_stored),
        .evicted_one  (evicted_one),
        .pop_valid    (pop_valid),
        .out_priority (out_priority),
        .out_payload  (out_payload),
        .fill_level   (fill_level),
        .drop_total   (drop_total)
    );

    perq_scan u_scan (
        .clk        (clk),
        .ctl        (scan_ctl),
        .prio       (scan_prio),
        .age        (scan_age),
        .low_prio   (low_prio),
        .victim_age (victim_age)
    );

endmodule

// ===== hdl/perq_check.sv =====
// Port-level checker for the priority evicting ring queue, bound to the top level.
module perq_check (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        busy,
    input logic                        done,
    input logic                        push_stored,
    input logic                        evicted_one,
    input logic                        pop_valid,
    input perq_pkg::prio_t             out_priority,
    input logic [perq_pkg::PORT_W-1:0] out_payload,
    input logic [perq_pkg::FILL_W-1:0] fill_level,
    input logic [perq_pkg::DROP_W-1:0] drop_total
);
    import perq_pkg::*;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result beat while busy");

    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(pop_valid && (push_stored || evicted_one)) && (!evicted_one || push_stored))
        else $error("inconsistent result flags");

    a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !pop_valid) |-> (out_priority == '0) && (out_payload == '0))
        else $error("nonzero data without a popped sample");

    a_fill: assert property (@(posedge clk) disable iff (!rst_n)
        fill_level <= FILL_W'(CAPACITY))
        else $error("fill level beyond capacity");

    a_drop_mono: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) |-> (drop_total >= $past(drop_total)))
        else $error("drop total decreased");

endmodule

bind priority_evicting_ring_queue perq_check u_perq_check (.*);
